// ===== src/ses_pkg.sv =====
`timescale 1ns / 1ps

package ses_pkg;

  localparam int STORE_BYTES  = 1024;
  localparam int NOTE_ENTRIES = 128;

  localparam int ADDR_W = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int NOTE_W = (NOTE_ENTRIES > 1) ? $clog2(NOTE_ENTRIES) : 1;
  localparam int SUM_W  = 18;

  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  localparam logic [1:0] OP_LOAD_BYTE = 2'd0;
  localparam logic [1:0] OP_LOAD_FREQ = 2'd1;
  localparam logic [1:0] OP_START     = 2'd2;
  localparam logic [1:0] OP_TICK      = 2'd3;

  localparam logic [1:0] TGT_ENV   = 2'd0;
  localparam logic [1:0] TGT_PULSE = 2'd1;
  localparam logic [1:0] TGT_FREQ  = 2'd2;
  localparam logic [1:0] TGT_CTRL  = 2'd3;

  localparam logic [7:0] GATE_MASK  = 8'hFE;
  localparam logic [7:0] WAVE_LIMIT = 8'h82;
  localparam logic [7:0] TEST_GATE  = 8'h09;

  typedef struct packed {
    logic       last;
    logic [7:0] gate_mask;
    logic [15:0] value;
    logic [1:0] target;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t res;
  } push_t;

endpackage

// ===== src/sound_effect_sequencer.sv =====
`timescale 1ns / 1ps

// Sound-effect sequencer for one voice of a sound chip.
// Input items arrive on the s_ channel: s_tuser carries the operation (load effect
// byte, load frequency entry, start effect, frame tick), s_tdata the address and data.
// Output items on the m_ channel are register writes: m_tuser names the register,
// m_tdata carries the value and the gate mask, and m_tlast marks the final write of a tick.
// Loads and starts may follow one another in every cycle while the result queue has room.
// A tick in the first frame pushes its write into the queue when accepted; the envelope
// frame steps through states AD, SR, PW and GATE, a note frame through NOTE, FREQ and,
// after a wave byte, WAVE, and an ending frame through NOTE, paced by the registered
// reads of the effect store and note table. Ticks wait until the four-entry result queue
// has room for three writes; a stalled receiver fills it, s_tready falls, nothing is lost.
// Reset clears the frame position and effect base; the effect store and the note
// table hold no defined contents until loaded, and no clearing pass is run.

module sound_effect_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // address [9:0], data [25:10], zero above
  input  logic [1:0]  s_tuser,   // opcode [1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // value [15:0], gate_mask [23:16]
  output logic [1:0]  m_tuser,   // target [1:0]
  output logic        m_tlast
);

  logic             accept;
  logic             idle;
  logic             room;
  ses_pkg::push_t   push;
  ses_pkg::result_t head;

  assign s_tready = idle && room;
  assign accept   = s_tvalid && s_tready;

  ses_engine u_engine (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .opcode  (s_tuser),
    .address (s_tdata[9:0]),
    .data    (s_tdata[25:10]),
    .idle    (idle),
    .push    (push)
  );

  ses_out_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .room     (room),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .head     (head)
  );

  assign m_tdata = {head.gate_mask, head.value};
  assign m_tuser = head.target;
  assign m_tlast = head.last;

endmodule

// ===== src/ses_ram.sv =====
`timescale 1ns / 1ps

module ses_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/ses_engine.sv =====
`timescale 1ns / 1ps

module ses_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [1:0]        opcode,
  input  logic [9:0]        address,
  input  logic [15:0]       data,
  output logic              idle,
  output ses_pkg::push_t    push
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_AD   = 3'd1;
  localparam logic [2:0] S_SR   = 3'd2;
  localparam logic [2:0] S_PW   = 3'd3;
  localparam logic [2:0] S_GATE = 3'd4;
  localparam logic [2:0] S_NOTE = 3'd5;
  localparam logic [2:0] S_FREQ = 3'd6;
  localparam logic [2:0] S_WAVE = 3'd7;

  logic [2:0]  state;
  logic [2:0]  state_next;
  logic [7:0]  frame_position;
  logic [7:0]  frame_position_next;
  logic [9:0]  effect_base;
  logic [9:0]  effect_base_next;
  logic [7:0]  offset;
  logic [7:0]  ad_byte;
  logic [7:0]  wave_byte;
  logic        idx_ok;
  logic [8:0]  rd_offset;
  logic        is_wave;

  logic [ses_pkg::SUM_W-1:0]  rd_sum;
  logic [ses_pkg::SUM_W-1:0]  wr_sum;
  logic [ses_pkg::ADDR_W-1:0] store_raddr;
  logic [ses_pkg::ADDR_W-1:0] store_waddr;
  logic [7:0]                 store_rdata;
  logic                       store_we;
  logic [ses_pkg::NOTE_W-1:0] note_raddr;
  logic [ses_pkg::NOTE_W-1:0] note_waddr;
  logic [15:0]                note_rdata;
  logic                       note_we;

  assign rd_sum      = ses_pkg::SUM_W'(effect_base) + ses_pkg::SUM_W'(rd_offset);
  assign store_raddr = rd_sum[ses_pkg::ADDR_W-1:0];
  assign wr_sum      = ses_pkg::SUM_W'(address);
  assign store_waddr = wr_sum[ses_pkg::ADDR_W-1:0];
  assign store_we    = accept && (opcode == ses_pkg::OP_LOAD_BYTE);
  assign note_we     = accept && (opcode == ses_pkg::OP_LOAD_FREQ)
                       && (address < 10'(ses_pkg::NOTE_ENTRIES));
  assign note_waddr  = ses_pkg::NOTE_W'(address);
  assign note_raddr  = ses_pkg::NOTE_W'(store_rdata[6:0]);
  assign is_wave     = (store_rdata != 8'd0) && (store_rdata < ses_pkg::WAVE_LIMIT);
  assign idle        = (state == S_IDLE);

  ses_ram #(.WIDTH(8), .DEPTH(ses_pkg::STORE_BYTES)) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (store_waddr),
    .wdata (data[7:0]),
    .raddr (store_raddr),
    .rdata (store_rdata)
  );

  ses_ram #(.WIDTH(16), .DEPTH(ses_pkg::NOTE_ENTRIES)) u_notes (
    .clk   (clk),
    .we    (note_we),
    .waddr (note_waddr),
    .wdata (data),
    .raddr (note_raddr),
    .rdata (note_rdata)
  );

  always_comb begin
    state_next          = state;
    frame_position_next = frame_position;
    effect_base_next    = effect_base;
    rd_offset           = 9'd0;
    push                = '0;
    push.res.gate_mask  = ses_pkg::GATE_MASK;
    unique case (state)
      S_IDLE: begin
        rd_offset = (frame_position == 8'd2) ? 9'd0 : {1'b0, frame_position};
        if (accept) begin
          unique case (opcode)
            ses_pkg::OP_START: begin
              if ((frame_position == 8'd0) || (address > effect_base)) begin
                frame_position_next = 8'd1;
                effect_base_next    = address;
              end
            end
            ses_pkg::OP_TICK: begin
              if (frame_position != 8'd0) begin
                frame_position_next = frame_position + 8'd1;
                if (frame_position == 8'd1) begin
                  push.valid      = 1'b1;
                  push.res.target = ses_pkg::TGT_ENV;
                  push.res.value  = 16'd0;
                  push.res.last   = 1'b1;
                end else if (frame_position == 8'd2) begin
                  state_next = S_AD;
                end else begin
                  state_next = S_NOTE;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_AD: begin
        rd_offset  = 9'd1;
        state_next = S_SR;
      end
      S_SR: begin
        rd_offset       = 9'd2;
        push.valid      = 1'b1;
        push.res.target = ses_pkg::TGT_ENV;
        push.res.value  = {ad_byte, store_rdata};
        state_next      = S_PW;
      end
      S_PW: begin
        push.valid      = 1'b1;
        push.res.target = ses_pkg::TGT_PULSE;
        push.res.value  = {store_rdata, store_rdata};
        state_next      = S_GATE;
      end
      S_GATE: begin
        push.valid      = 1'b1;
        push.res.target = ses_pkg::TGT_CTRL;
        push.res.value  = {8'd0, ses_pkg::TEST_GATE};
        push.res.last   = 1'b1;
        state_next      = S_IDLE;
      end
      S_NOTE: begin
        rd_offset = {1'b0, offset} + 9'd1;
        if (store_rdata == 8'd0) begin
          push.valid          = 1'b1;
          push.res.target     = ses_pkg::TGT_CTRL;
          push.res.value      = {8'd0, ses_pkg::TEST_GATE};
          push.res.last       = 1'b1;
          frame_position_next = 8'd0;
          effect_base_next    = 10'd0;
          state_next          = S_IDLE;
        end else begin
          state_next = S_FREQ;
        end
      end
      S_FREQ: begin
        push.valid      = 1'b1;
        push.res.target = ses_pkg::TGT_FREQ;
        push.res.value  = idx_ok ? note_rdata : 16'd0;
        push.res.last   = !is_wave;
        if (is_wave) begin
          frame_position_next = frame_position + 8'd1;
          state_next          = S_WAVE;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_WAVE: begin
        push.valid      = 1'b1;
        push.res.target = ses_pkg::TGT_CTRL;
        push.res.value  = {8'd0, wave_byte};
        push.res.last   = 1'b1;
        state_next      = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      frame_position <= 8'd0;
      effect_base    <= 10'd0;
    end else begin
      state          <= state_next;
      frame_position <= frame_position_next;
      effect_base    <= effect_base_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      offset <= frame_position;
    end
    if (state == S_AD) begin
      ad_byte <= store_rdata;
    end
    if (state == S_NOTE) begin
      idx_ok <= ({1'b0, store_rdata[6:0]} < 8'(ses_pkg::NOTE_ENTRIES));
    end
    if (state == S_FREQ) begin
      wave_byte <= store_rdata;
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |-> (state == S_IDLE))
    else $error("Item accepted while a tick is in progress.");

  a_last_ends_tick: assert property (@(posedge clk) disable iff (rst)
    (push.valid && push.res.last) |=> (state == S_IDLE))
    else $error("Sequencer still busy after the final write of a tick.");

  a_stay_idle: assert property (@(posedge clk) disable iff (rst)
    ((state == S_IDLE) && !accept) |=> (state == S_IDLE))
    else $error("Sequencer left idle without an accepted item.");

endmodule

// ===== src/ses_out_queue.sv =====
`timescale 1ns / 1ps

module ses_out_queue (
  input  logic                clk,
  input  logic                rst,
  input  ses_pkg::push_t      push,
  output logic                room,
  output logic                m_tvalid,
  input  logic                m_tready,
  output ses_pkg::result_t    head
);

  ses_pkg::result_t             entries [ses_pkg::OQ_DEPTH];
  logic [ses_pkg::OQ_PTR_W-1:0] wr_ptr;
  logic [ses_pkg::OQ_PTR_W-1:0] rd_ptr;
  logic [ses_pkg::OQ_CNT_W-1:0] count;
  logic                         pop;

  assign pop      = m_tvalid && m_tready;
  assign m_tvalid = (count != '0);
  assign head     = entries[rd_ptr];
  assign room     = (count <= ses_pkg::OQ_CNT_W'(ses_pkg::OQ_DEPTH - 3));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push.valid && !pop) begin
        count <= count + 1'b1;
      end else if (!push.valid && pop) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      entries[wr_ptr] <= push.res;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> ((count != ses_pkg::OQ_CNT_W'(ses_pkg::OQ_DEPTH)) || pop))
    else $error("Result queue written while full.");

endmodule
